// ----- hw/rtl/cbdf_pkg.sv -----
// Shared constants, register codes and pipeline types for the CCD
// bias/dark/flat correction block. No dependencies.
package cbdf_pkg;

    localparam int PIXEL_BITS = 16;
    localparam int COORD_BITS = 12;
    localparam int DARK_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int EXP_W      = 16;
    localparam int OUT_W      = 32;
    localparam int PROD_W     = DARK_W + EXP_W;

    // magnitude of the Q.16 sum, its signed form, and the divider numerator
    localparam int MAG_W = ((PIXEL_BITS + 16 > PROD_W) ? PIXEL_BITS + 16 : PROD_W) + 1;
    localparam int V_W   = MAG_W + 1;
    localparam int NUM_W = MAG_W + 7;

    localparam int IN_W       = 2 * PIXEL_BITS + DARK_W + GAIN_W + 2 * COORD_BITS;
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
    localparam int CFG_W      = (COORD_BITS + 1 > EXP_W) ? COORD_BITS + 1 : EXP_W;

    localparam logic [GAIN_W-1:0] FLAT_THRESHOLD = GAIN_W'(16);
    localparam logic [GAIN_W-1:0] UNIT_DIV       = GAIN_W'(256);
    localparam logic [MAG_W-1:0]  RND_HALF       = MAG_W'(128);
    localparam logic [EXP_W-1:0]  EXPOSURE_RST   = EXP_W'(256);

    localparam logic [NUM_W-1:0] SAT_POS_LIM = {{(NUM_W-32){1'b0}}, 32'h7fff_ffff};
    localparam logic [NUM_W-1:0] SAT_NEG_LIM = {{(NUM_W-32){1'b0}}, 32'h8000_0000};

    typedef enum logic [2:0] {
        REG_EXPOSURE = 3'd0,
        REG_USE_BIAS = 3'd1,
        REG_USE_DARK = 3'd2,
        REG_USE_FLAT = 3'd3,
        REG_X_START  = 3'd4,
        REG_X_END    = 3'd5,
        REG_Y_START  = 3'd6,
        REG_Y_END    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [EXP_W-1:0]    exposure;
        logic                use_bias;
        logic                use_dark;
        logic                use_flat;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS:0]   x_end;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS:0]   y_end;
    } cfg_t;

    // one word traveling down the divider cells
    typedef struct packed {
        logic              valid;
        logic              last;
        logic              applied;
        logic              status;
        logic              neg;
        logic [GAIN_W-1:0] dvsr;
        logic [GAIN_W-1:0] rem;
        logic [NUM_W-1:0]  work;
    } quo_word_t;

endpackage

// ----- hw/rtl/cbdf_front.sv -----
// Front end: dark product, Q.16 sum, sign/magnitude and numerator setup.
// Depends on cbdf_pkg.
module cbdf_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cbdf_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [cbdf_pkg::PIXEL_BITS-1:0] raw_pixel,
    input  logic [cbdf_pkg::PIXEL_BITS-1:0] bias_pixel,
    input  logic [cbdf_pkg::DARK_W-1:0]     dark_rate,
    input  logic [cbdf_pkg::GAIN_W-1:0]     flat_gain,
    input  logic [cbdf_pkg::COORD_BITS-1:0] col,
    input  logic [cbdf_pkg::COORD_BITS-1:0] row,
    input  logic                           last_pixel,
    output cbdf_pkg::quo_word_t            out_word,
    input  logic                           out_ready
);
    import cbdf_pkg::*;

    logic                  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                  r1, r2, r3;
    logic [PIXEL_BITS-1:0] s1_raw_reg, s1_bias_reg, s2_raw_reg;
    logic [PROD_W-1:0]     s1_prod_reg;
    logic [GAIN_W-1:0]     s1_gain_reg, s2_gain_reg;
    logic                  s1_div_reg, s1_status_reg, s1_last_reg;
    logic                  s2_div_reg, s2_status_reg, s2_last_reg;
    logic [V_W-1:0]        s2_v_reg;
    quo_word_t             s3_word_reg;

    logic                  in_zone, zone_all;
    logic                  s1_div_next, s1_status_next;
    logic [PROD_W-1:0]     prod_next;
    logic [V_W-1:0]        v_next;
    logic [MAG_W-1:0]      mag;
    logic                  neg;
    quo_word_t             s3_word_next;

    assign r3       = !s3_valid_reg || out_ready;
    assign r2       = !s2_valid_reg || r3;
    assign r1       = !s1_valid_reg || r2;
    assign in_ready = r1;

    always_comb
    begin
        zone_all = (cfg.x_end == {1'b0, cfg.x_start});
        in_zone  = zone_all ||
                   (col >= cfg.x_start && {1'b0, col} < cfg.x_end &&
                    row >= cfg.y_start && {1'b0, row} < cfg.y_end);
        s1_status_next = cfg.use_flat && !cfg.use_bias;
        s1_div_next    = cfg.use_flat && cfg.use_bias && in_zone &&
                         (flat_gain > FLAT_THRESHOLD);
        prod_next      = cfg.use_dark ? PROD_W'(dark_rate * cfg.exposure) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (r1)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            s1_raw_reg    <= raw_pixel;
            s1_bias_reg   <= cfg.use_bias ? bias_pixel : '0;
            s1_prod_reg   <= prod_next;
            s1_gain_reg   <= flat_gain;
            s1_div_reg    <= s1_div_next;
            s1_status_reg <= s1_status_next;
            s1_last_reg   <= last_pixel;
        end
    end

    // Q.16 sum: (raw - bias) * 2^16 - dark * exposure
    assign v_next = V_W'({s1_raw_reg, 16'b0}) - V_W'({s1_bias_reg, 16'b0})
                    - V_W'(s1_prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (r2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r2)
        begin
            s2_v_reg      <= v_next;
            s2_raw_reg    <= s1_raw_reg;
            s2_gain_reg   <= s1_gain_reg;
            s2_div_reg    <= s1_div_reg;
            s2_status_reg <= s1_status_reg;
            s2_last_reg   <= s1_last_reg;
        end
    end

    // Fold every case into one rounded division: rejected frames divide raw * 2^16 by 256,
    // flat pixels divide |v| * 2^6 + gain/2 by the gain, plain pixels divide |v| + 128 by 256.
    always_comb
    begin
        neg = s2_v_reg[V_W-1] && !s2_status_reg;
        mag = s2_v_reg[V_W-1] ? MAG_W'(-s2_v_reg) : s2_v_reg[MAG_W-1:0];
        s3_word_next         = '0;
        s3_word_next.valid   = s2_valid_reg;
        s3_word_next.last    = s2_last_reg;
        s3_word_next.applied = s2_div_reg;
        s3_word_next.status  = s2_status_reg;
        s3_word_next.neg     = neg;
        if (s2_status_reg)
        begin
            s3_word_next.work = NUM_W'({s2_raw_reg, 16'b0});
            s3_word_next.dvsr = UNIT_DIV;
        end
        else if (s2_div_reg)
        begin
            s3_word_next.work = NUM_W'({mag, 6'b0}) + NUM_W'(s2_gain_reg >> 1);
            s3_word_next.dvsr = s2_gain_reg;
        end
        else
        begin
            s3_word_next.work = NUM_W'(mag) + NUM_W'(RND_HALF);
            s3_word_next.dvsr = UNIT_DIV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (r3)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r3)
        begin
            s3_word_reg <= s3_word_next;
        end
    end

    always_comb
    begin
        out_word       = s3_word_reg;
        out_word.valid = s3_valid_reg;
    end

endmodule

// ----- hw/rtl/cbdf_div_cell.sv -----
// One restoring-division cell: resolves one quotient bit per pass.
// Depends on cbdf_pkg.
module cbdf_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  cbdf_pkg::quo_word_t in_word,
    output logic                in_ready,
    output cbdf_pkg::quo_word_t out_word,
    input  logic                out_ready
);
    import cbdf_pkg::*;

    quo_word_t         word_reg;
    quo_word_t         word_next;
    logic [GAIN_W:0]   trial;
    logic              ge;

    assign in_ready = !word_reg.valid || out_ready;

    always_comb
    begin
        trial     = {in_word.rem, in_word.work[NUM_W-1]};
        ge        = trial >= {1'b0, in_word.dvsr};
        word_next = in_word;
        word_next.rem  = ge ? GAIN_W'(trial - {1'b0, in_word.dvsr}) : trial[GAIN_W-1:0];
        word_next.work = {in_word.work[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (in_ready)
        begin
            word_reg <= word_next;
        end
    end

    assign out_word = word_reg;

endmodule

// ----- hw/rtl/ccd_bias_dark_flat_correct.sv -----
// Top level of the CCD bias/dark/flat correction stream.
// Depends on cbdf_pkg, cbdf_front and cbdf_div_cell.
// Pipeline: three front stages, one divider cell per quotient bit (40), and
// the output register.
// Throughput: one pixel per cycle while m_tready does not stall the output; each divider
// cell handles one bit of a different pixel, so a new transfer enters every cycle.
// Reset: empties the pipeline; registers return to exposure 1.0 s, all corrections off
// and x_end equal to x_start, which makes the zone cover the whole frame.
module ccd_bias_dark_flat_correct (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [2:0]                       cfg_index,
    input  logic [cbdf_pkg::CFG_W-1:0]       cfg_data,
    // pixel input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // raw_pixel, bias_pixel, dark_rate, flat_gain, col, row (low bit up)
    input  logic [cbdf_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tlast,   // last_pixel
    // corrected output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cbdf_pkg::OUT_W-1:0]       m_tdata,   // corrected_pixel
    output logic [1:0]                       m_tuser,   // flat_applied (bit 0), status (bit 1)
    output logic                             m_tlast    // last_out
);
    import cbdf_pkg::*;

    localparam int B0 = PIXEL_BITS;
    localparam int B1 = 2 * PIXEL_BITS;
    localparam int B2 = B1 + DARK_W;
    localparam int B3 = B2 + GAIN_W;
    localparam int B4 = B3 + COORD_BITS;
    localparam int B5 = B4 + COORD_BITS;

    cfg_t              cfg_reg;
    quo_word_t         chain [0:NUM_W];
    logic              rdy   [0:NUM_W];

    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic [1:0]        out_user_reg;
    logic              out_last_reg;
    logic [OUT_W-1:0]  sat_value;
    quo_word_t         fin;

    // Configuration: always ready, unknown codes cannot occur in 3 bits.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg          <= '0;
            cfg_reg.exposure <= EXPOSURE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_EXPOSURE: cfg_reg.exposure <= cfg_data[EXP_W-1:0];
                REG_USE_BIAS: cfg_reg.use_bias <= cfg_data[0];
                REG_USE_DARK: cfg_reg.use_dark <= cfg_data[0];
                REG_USE_FLAT: cfg_reg.use_flat <= cfg_data[0];
                REG_X_START:  cfg_reg.x_start  <= cfg_data[COORD_BITS-1:0];
                REG_X_END:    cfg_reg.x_end    <= cfg_data[COORD_BITS:0];
                REG_Y_START:  cfg_reg.y_start  <= cfg_data[COORD_BITS-1:0];
                REG_Y_END:    cfg_reg.y_end    <= cfg_data[COORD_BITS:0];
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    // Front end: product, sum and numerator setup over three stages.
    cbdf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .raw_pixel  (s_tdata[B0-1:0]),
        .bias_pixel (s_tdata[B1-1:B0]),
        .dark_rate  (s_tdata[B2-1:B1]),
        .flat_gain  (s_tdata[B3-1:B2]),
        .col        (s_tdata[B4-1:B3]),
        .row        (s_tdata[B5-1:B4]),
        .last_pixel (s_tlast),
        .out_word   (chain[0]),
        .out_ready  (rdy[0])
    );

    // Divider chain: each cell shifts in one quotient bit, MSB first.
    // A cell advances whenever it is empty or its neighbor moves, so
    // bubbles collapse while the output waits.
    for (genvar k = 0; k < NUM_W; k++)
    begin : g_cell
        cbdf_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_word   (chain[k]),
            .in_ready  (rdy[k]),
            .out_word  (chain[k+1]),
            .out_ready (rdy[k+1])
        );
    end

    assign fin = chain[NUM_W];

    // Apply the sign and saturate to the signed 32-bit range.
    always_comb
    begin
        if (fin.neg)
        begin
            sat_value = (fin.work > SAT_NEG_LIM) ? 32'h8000_0000
                                                 : (~fin.work[OUT_W-1:0]) + 32'd1;
        end
        else
        begin
            sat_value = (fin.work > SAT_POS_LIM) ? 32'h7fff_ffff : fin.work[OUT_W-1:0];
        end
    end

    // Output register: take a new result when empty or when the current
    // transfer completes.
    assign rdy[NUM_W] = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rdy[NUM_W])
        begin
            out_valid_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NUM_W])
        begin
            out_data_reg <= sat_value;
            out_user_reg <= {fin.status, fin.applied};
            out_last_reg <= fin.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // A rejected frame never reports a division.
    a_status_no_flat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("status set together with flat_applied");

    // A rejected frame passes raw * 2^8, which is never negative.
    a_status_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tdata[OUT_W-1])
        else $error("rejected frame produced a negative value");

    // With the output empty every cell drains, so the input must be ready.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output empty");

endmodule
